@@ sv/trial_division_prime_test_assert.svh @@
// Assertion macros for the trial-division prime tester.
// Used by trial_division_prime_test.sv; expects clk_i and rst_ni in scope.
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

`ifndef SYNTH
`define TDPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tdpt assertion failed");
`define TDPT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tdpt assertion failed");
`else
`define TDPT_ASSERT(lbl, prop)
`define TDPT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ sv/tdpt_pkg.sv @@
// Package for the trial-division prime tester: widths, microcode codes and the
// control store. No dependencies.
`timescale 1ns / 1ps

package tdpt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 2;
  localparam int SQ_WIDTH    = VALUE_WIDTH + 2;
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
  localparam int IN_BYTES_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int PC_W        = 4;

  typedef enum logic [2:0] {
    A_NONE,
    A_LOAD,
    A_DIV_INIT,
    A_DIV_STEP,
    A_ADVANCE,
    A_SET_PRIME,
    A_SET_COMP
  } act_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_ACC,
    C_LT2,
    C_LT4,
    C_EVEN,
    C_SQ_GT,
    C_NOT_LAST,
    C_REM_ZERO,
    C_BLOCKED
  } cond_e;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] tgt;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_WAIT   = 4'd0;
  localparam logic [PC_W-1:0] PC_LT2    = 4'd1;
  localparam logic [PC_W-1:0] PC_LT4    = 4'd2;
  localparam logic [PC_W-1:0] PC_EVEN   = 4'd3;
  localparam logic [PC_W-1:0] PC_LOOP   = 4'd4;
  localparam logic [PC_W-1:0] PC_DIV    = 4'd5;
  localparam logic [PC_W-1:0] PC_REM    = 4'd6;
  localparam logic [PC_W-1:0] PC_NEXT   = 4'd7;
  localparam logic [PC_W-1:0] PC_PRIME  = 4'd8;
  localparam logic [PC_W-1:0] PC_PDONE  = 4'd9;
  localparam logic [PC_W-1:0] PC_COMP   = 4'd10;
  localparam logic [PC_W-1:0] PC_CDONE  = 4'd11;

  // Jump to tgt when cond holds, else fall through to the next step.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_WAIT:  w = '{A_LOAD,      C_NO_ACC,   PC_WAIT};
      PC_LT2:   w = '{A_NONE,      C_LT2,      PC_COMP};
      PC_LT4:   w = '{A_NONE,      C_LT4,      PC_PRIME};
      PC_EVEN:  w = '{A_NONE,      C_EVEN,     PC_COMP};
      PC_LOOP:  w = '{A_DIV_INIT,  C_SQ_GT,    PC_PRIME};
      PC_DIV:   w = '{A_DIV_STEP,  C_NOT_LAST, PC_DIV};
      PC_REM:   w = '{A_NONE,      C_REM_ZERO, PC_COMP};
      PC_NEXT:  w = '{A_ADVANCE,   C_ALWAYS,   PC_LOOP};
      PC_PRIME: w = '{A_SET_PRIME, C_BLOCKED,  PC_PRIME};
      PC_PDONE: w = '{A_NONE,      C_ALWAYS,   PC_WAIT};
      PC_COMP:  w = '{A_SET_COMP,  C_BLOCKED,  PC_COMP};
      PC_CDONE: w = '{A_NONE,      C_ALWAYS,   PC_WAIT};
      default:  w = '{A_NONE,      C_ALWAYS,   PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ sv/trial_division_prime_test.sv @@
// Trial-division prime tester: microcoded sequencer over a bit-serial remainder unit.
// Depends on tdpt_pkg and trial_division_prime_test_assert.svh.
//
//  channel   dir  word contents                    handshake
//  s_axis    in   tdata[31:0] candidate            tvalid/tready
//  m_axis    out  tdata[0] is_prime_flag, rest 0   tvalid/tready
//
// One candidate at a time. Each trial divisor runs the loop test, one remainder step
// per candidate bit in the one-bit-per-cycle remainder unit, the zero test and the
// divisor advance. Values below 4 and even values are decided before the loop. Reset
// clears the step counter and the output valid. A result waits in the output
// register; the sequencer stalls only if a second one is ready.
`timescale 1ns / 1ps
`include "trial_division_prime_test_assert.svh"

module trial_division_prime_test
  import tdpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_BYTES_W-1:0] s_axis_tdata,  // [VALUE_WIDTH-1:0] candidate
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata   // [0] is_prime_flag, [7:1] zero
);

  logic [PC_W-1:0]        pc_q, pc_d;
  logic [VALUE_WIDTH-1:0] n_q, nsh_q;
  logic [DIV_WIDTH-1:0]   d_q, rem_q;
  logic [SQ_WIDTH-1:0]    sq_q;
  logic [CNT_WIDTH-1:0]   cnt_q;
  logic                   out_valid_q, out_flag_q;

  ctrl_t                  cw;
  logic                   accept, blocked, cond_hit, out_load;
  logic [DIV_WIDTH:0]     trial;
  logic [DIV_WIDTH-1:0]   rem_d;

  assign cw            = ucode(pc_q);
  assign s_axis_tready = (pc_q == PC_WAIT);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign blocked       = out_valid_q && !m_axis_tready;
  assign out_load      = ((cw.act == A_SET_PRIME) || (cw.act == A_SET_COMP)) && !blocked;

  assign trial = {rem_q, nsh_q[VALUE_WIDTH-1]};
  always_comb begin
    if (trial >= {1'b0, d_q}) begin
      rem_d = DIV_WIDTH'(trial - {1'b0, d_q});
    end else begin
      rem_d = trial[DIV_WIDTH-1:0];
    end
  end

  always_comb begin
    case (cw.cond)
      C_ALWAYS:   cond_hit = 1'b1;
      C_NO_ACC:   cond_hit = !s_axis_tvalid;
      C_LT2:      cond_hit = (n_q[VALUE_WIDTH-1:1] == '0);
      C_LT4:      cond_hit = (n_q[VALUE_WIDTH-1:2] == '0);
      C_EVEN:     cond_hit = !n_q[0];
      C_SQ_GT:    cond_hit = (sq_q > {2'b00, n_q});
      C_NOT_LAST: cond_hit = (cnt_q != CNT_WIDTH'(VALUE_WIDTH - 1));
      C_REM_ZERO: cond_hit = (rem_q == '0);
      C_BLOCKED:  cond_hit = blocked;
      default:    cond_hit = 1'b1;
    endcase
    pc_d = cond_hit ? cw.tgt : PC_W'(pc_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cw.act)
      A_LOAD: begin
        if (accept) begin
          n_q  <= s_axis_tdata[VALUE_WIDTH-1:0];
          d_q  <= DIV_WIDTH'(3);
          sq_q <= SQ_WIDTH'(9);
        end
      end
      A_DIV_INIT: begin
        rem_q <= '0;
        cnt_q <= '0;
        nsh_q <= n_q;
      end
      A_DIV_STEP: begin
        rem_q <= rem_d;
        cnt_q <= CNT_WIDTH'(cnt_q + 1'b1);
        nsh_q <= {nsh_q[VALUE_WIDTH-2:0], 1'b0};
      end
      A_ADVANCE: begin
        // (d + 2)^2 = d^2 + 4d + 4
        d_q  <= DIV_WIDTH'(d_q + 2'd2);
        sq_q <= SQ_WIDTH'(sq_q + SQ_WIDTH'({d_q, 2'b00}) + SQ_WIDTH'(4));
      end
      A_SET_PRIME: if (out_load) out_flag_q <= 1'b1;
      A_SET_COMP:  if (out_load) out_flag_q <= 1'b0;
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_flag_q};

  `TDPT_ASSERT(a_accept_then_range, accept |=> (pc_q == PC_LT2))
  `TDPT_ASSERT(a_rem_below_divisor, (pc_q == PC_DIV) |-> (rem_q < d_q))
  `TDPT_ASSERT(a_divisor_odd, (pc_q == PC_DIV) |-> d_q[0])
  `TDPT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (pc_q == PC_WAIT) || $past(rst_ni))

endmodule

@@ sim/tb_trial_division_prime_test.sv @@
// Self-checking bench for trial_division_prime_test: drives candidate words over the
// input stream and compares each returned flag with a trial-division verdict.
// Depends on tdpt_pkg and the trial_division_prime_test RTL.
`timescale 1ns / 1ps

module tb_trial_division_prime_test;
  import tdpt_pkg::*;

  typedef logic [VALUE_WIDTH-1:0] candidate_t;

  typedef struct {
    candidate_t value;
    bit         prime;
  } verdict_t;

  class prime_scoreboard;
    verdict_t verdicts[$];
    int       errors;
    int       flags_seen;

    function new();
      errors     = 0;
      flags_seen = 0;
    endfunction

    function bit divides_out(longint unsigned n);
      longint unsigned d;
      if (n < 2) return 1'b0;
      if (n < 4) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      for (d = 3; d <= n / d; d += 2) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_candidate(candidate_t c);
      verdict_t v;
      v.value = c;
      v.prime = divides_out(longint'(c));
      verdicts.insert(verdicts.size(), v);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_flag(logic [7:0] word);
      verdict_t v;
      flags_seen++;
      if (verdicts.size() == 0) begin
        report($sformatf("flag word %h with no candidate pending", word));
      end else begin
        v = verdicts.pop_front();
        if (word[0] !== v.prime)
          report($sformatf("candidate %0d: flag %b, want %b", v.value, word[0], v.prime));
        if (word[7:1] !== 7'd0)
          report($sformatf("candidate %0d: padding bits %b", v.value, word[7:1]));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_BYTES_W-1:0] s_axis_tdata;   // [VALUE_WIDTH-1:0] candidate
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;   // [0] is_prime_flag, [7:1] zero

  prime_scoreboard sb = new();
  bit              calm = 1'b0;
  bit              held = 1'b0;

  trial_division_prime_test uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
  end

  task send_candidate(candidate_t c);
    s_axis_tdata  <= IN_BYTES_W'(c);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_candidate(c);
  endtask

  task idle_sender(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic candidate_t pick_candidate();
    candidate_t x;
    int unsigned factors[6] = '{2, 3, 5, 7, 11, 13};
    int unsigned p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pick_candidate = candidate_t'($urandom_range(0, 65535));
      4:          pick_candidate = candidate_t'($urandom_range(0, 1 << 20));
      default: begin
        // keep wide values cheap: force a small factor
        x = candidate_t'($urandom);
        p = factors[$urandom_range(0, 5)];
        pick_candidate = x - (x % p);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_flag(m_axis_tdata);
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!held && sb.flags_seen >= 10) begin
        // hold off long enough for the block to back up its input
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (20000) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 1)) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    candidate_t directed[$];
    int n;

    directed = {
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
      32'd63001, 32'd65521, 32'd65536, 32'd65537,
      32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
      32'hAAAA_AAAA, 32'h5555_5555, 32'd999983, 32'd1000003
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_candidate(directed[i]);

    for (n = 0; n < 80; n++) begin
      if (n >= 64) calm = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 19));
      send_candidate(pick_candidate());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.verdicts.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
